// ----- sv/brfp_pkg.sv -----
package brfp_pkg;

   localparam int STORE_DEPTH = 256;
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int LEN_W = 8;
   localparam int CMP_W = ((IDX_W > LEN_W) ? IDX_W : LEN_W) + 1;

   localparam logic [1:0] FN_ADD    = 2'd0;
   localparam logic [1:0] FN_REMOVE = 2'd1;
   localparam logic [1:0] FN_PEEK   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] write_byte;
      logic [7:0] peek_offset;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] read_byte;
      logic       is_full;
      logic       is_empty;
   } rsp_type;

   function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] value);
      logic [LEN_W-1:0] len;
      len = (value == '0) ? LEN_W'(1) : value;
      if (CMP_W'(len) > CMP_W'(STORE_DEPTH)) begin
         len = LEN_W'(STORE_DEPTH);
      end
      return len;
   endfunction

   function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                  input logic [LEN_W-1:0] len);
      logic [CMP_W-1:0] nxt;
      nxt = CMP_W'(idx) + CMP_W'(1);
      return (nxt >= CMP_W'(len)) ? '0 : IDX_W'(nxt);
   endfunction

endpackage

// ----- sv/byte_ring_fifo_with_peek_core.sv -----
// Byte FIFO in a ring store with head/tail/count and a peek port.
// Request channel: drive req_data and pulse start while busy is low; the
//   transaction is taken at that clock edge. busy is always low, so one
//   request can be issued every cycle (add, remove or peek).
// Result channel: exactly one result per request, on rsp_data with rsp_valid
//   high for one cycle, in the cycle after the request edge. The result is
//   registered, as is the read port of the ring store; throughput is one per cycle.
//   The receiver cannot stall; it must take each result when it appears.
// Configuration: csr_we/csr_wdata set the ring length (0 acts as 1, values
//   above the store depth act as the depth) and empty the FIFO. Write it only
//   when no request is outstanding.
// Reset (synchronous, active high): head, tail and count go to zero, ring
//   length goes to 255. Store contents are not cleared; a slot is only ever
//   read after an add wrote it. Status codes: ok, full, empty, bad access.
// read_byte is zero for adds and for any status other than ok.
module byte_ring_fifo_with_peek_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  brfp_pkg::req_type req_data,
   output logic              rsp_valid,
   output brfp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [7:0]        csr_wdata
);

   logic [brfp_pkg::IDX_W-1:0] head_ff, head_in;
   logic [brfp_pkg::IDX_W-1:0] tail_ff, tail_in;
   logic [brfp_pkg::CMP_W-1:0] count_ff, count_in, count_op;
   logic [brfp_pkg::LEN_W-1:0] length_ff, length_in;

   logic       valid_ff, valid_in;
   logic [1:0] status_ff, status_in;
   logic       rd_ok_ff, rd_ok_in;
   logic       full_ff, full_in;
   logic       empty_ff, empty_in;

   logic                       accept;
   logic                       wr_en;
   logic                       rd_en;
   logic [brfp_pkg::IDX_W-1:0] rd_addr;
   logic [7:0]                 rd_data;
   logic [brfp_pkg::CMP_W-1:0] len_ext;
   logic [brfp_pkg::CMP_W-1:0] off_ext;
   logic [brfp_pkg::CMP_W-1:0] slot_sum;
   logic [brfp_pkg::CMP_W-1:0] slot;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign len_ext  = brfp_pkg::CMP_W'(length_ff);
   assign off_ext  = brfp_pkg::CMP_W'(req_data.peek_offset);
   assign slot_sum = brfp_pkg::CMP_W'(head_ff) + off_ext;
   assign slot     = (slot_sum >= len_ext) ? (slot_sum - len_ext) : slot_sum;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_op  = count_ff;
      status_in = brfp_pkg::ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = head_ff;
      if (accept) begin
         case (req_data.func)
            brfp_pkg::FN_ADD: begin
               if (count_ff >= len_ext) begin
                  status_in = brfp_pkg::ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  tail_in  = brfp_pkg::next_index(tail_ff, length_ff);
                  count_op = count_ff + brfp_pkg::CMP_W'(1);
               end
            end
            brfp_pkg::FN_REMOVE: begin
               if (count_ff == '0) begin
                  status_in = brfp_pkg::ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_ok_in = 1'b1;
                  head_in  = brfp_pkg::next_index(head_ff, length_ff);
                  count_op = count_ff - brfp_pkg::CMP_W'(1);
               end
            end
            brfp_pkg::FN_PEEK: begin
               if (off_ext > len_ext) begin
                  status_in = brfp_pkg::ST_BAD;
               end else if (off_ext >= count_ff) begin
                  status_in = brfp_pkg::ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_ok_in = 1'b1;
                  rd_addr  = brfp_pkg::IDX_W'(slot);
               end
            end
            default: begin
               status_in = brfp_pkg::ST_BAD;
            end
         endcase
      end
      full_in   = (count_op == len_ext);
      empty_in  = (count_op == '0);
      valid_in  = accept;
      count_in  = count_op;
      length_in = length_ff;
      if (csr_we) begin
         length_in = brfp_pkg::clamp_length(csr_wdata);
         head_in   = '0;
         tail_in   = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         length_ff <= brfp_pkg::clamp_length(8'd255);
         valid_ff  <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         valid_ff  <= valid_in;
      end
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
      full_ff   <= full_in;
      empty_ff  <= empty_in;
   end

   brfp_ram #(
      .WIDTH(8),
      .DEPTH(brfp_pkg::STORE_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(req_data.write_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_valid          = valid_ff;
   assign rsp_data.status    = status_ff;
   assign rsp_data.read_byte = rd_ok_ff ? rd_data : 8'd0;
   assign rsp_data.is_full   = full_ff;
   assign rsp_data.is_empty  = empty_ff;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= brfp_pkg::CMP_W'(length_ff))
      else $error("item count exceeds ring length");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_full && rsp_data.is_empty))
      else $error("full and empty reported together");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction gave no result");

   a_byte_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != brfp_pkg::ST_OK) |-> rsp_data.read_byte == 8'd0)
      else $error("nonzero read byte with error status");
`endif

endmodule

// ----- sv/brfp_ram.sv -----
module brfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- tb/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FN_UNUSED  = 2'd3;
   localparam int         QUIET_MAX  = 2000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   brfp_pkg::req_type req_data;
   logic    rsp_valid;
   brfp_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [7:0] csr_wdata;

   byte_ring_fifo_with_peek_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // FIFO shadow state
   logic [7:0] shadow_mem [brfp_pkg::STORE_DEPTH];
   logic [7:0] shadow_head;
   logic [7:0] shadow_tail;
   logic [8:0] shadow_fill;
   logic [7:0] shadow_len;

   brfp_pkg::rsp_type rsp_due[$];
   int      mismatches = 0;
   int      burst_left = 0;
   int      req_by_func[4] = '{default: 0};
   int      status_seen[4] = '{default: 0};
   int      length_writes = 0;
   int      quiet_cycles = 0;

   function automatic logic [7:0] ring_advance(input logic [7:0] ptr);
      return (9'(ptr) + 9'd1 >= 9'(shadow_len)) ? 8'd0 : ptr + 8'd1;
   endfunction

   function automatic brfp_pkg::rsp_type fifo_apply(input brfp_pkg::req_type r);
      brfp_pkg::rsp_type o;
      logic [8:0]        slot;
      o = '0;
      o.status = brfp_pkg::ST_OK;
      case (r.func)
         brfp_pkg::FN_ADD: begin
            if (shadow_fill >= 9'(shadow_len)) begin
               o.status = brfp_pkg::ST_FULL;
            end else begin
               shadow_mem[shadow_tail] = r.write_byte;
               shadow_tail = ring_advance(shadow_tail);
               shadow_fill = shadow_fill + 9'd1;
            end
         end
         brfp_pkg::FN_REMOVE: begin
            if (shadow_fill == 9'd0) begin
               o.status = brfp_pkg::ST_EMPTY;
            end else begin
               o.read_byte = shadow_mem[shadow_head];
               shadow_mem[shadow_head] = 8'd0;
               shadow_head = ring_advance(shadow_head);
               shadow_fill = shadow_fill - 9'd1;
            end
         end
         brfp_pkg::FN_PEEK: begin
            if (r.peek_offset > shadow_len) begin
               o.status = brfp_pkg::ST_BAD;
            end else if (9'(r.peek_offset) >= shadow_fill) begin
               o.status = brfp_pkg::ST_EMPTY;
            end else begin
               slot = 9'(shadow_head) + 9'(r.peek_offset);
               if (slot >= 9'(shadow_len)) begin
                  slot = slot - 9'(shadow_len);
               end
               o.read_byte = shadow_mem[slot[7:0]];
            end
         end
         default: begin
            o.status = brfp_pkg::ST_BAD;
         end
      endcase
      o.is_full  = (shadow_fill == 9'(shadow_len));
      o.is_empty = (shadow_fill == 9'd0);
      return o;
   endfunction

   function automatic brfp_pkg::req_type req_of(input logic [1:0] f, input logic [7:0] b,
                                                input logic [7:0] o);
      brfp_pkg::req_type r;
      r.func        = f;
      r.write_byte  = b;
      r.peek_offset = o;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
         mismatches++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      brfp_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: unexpected transaction, expected none got %0h",
                     $time, rsp_data);
            mismatches++;
         end else begin
            e = rsp_due.pop_front();
            check_field("status",    8'(e.status),   8'(rsp_data.status));
            check_field("read_byte", e.read_byte,    rsp_data.read_byte);
            check_field("is_full",   8'(e.is_full),  8'(rsp_data.is_full));
            check_field("is_empty",  8'(e.is_empty), 8'(rsp_data.is_empty));
            status_seen[e.status]++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input brfp_pkg::req_type r);
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      rsp_due.push_back(fifo_apply(r));
      req_by_func[r.func]++;
   endtask

   task automatic issue(input brfp_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      send_request(r);
      burst_left--;
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(input logic [7:0] value);
      wait_all_results();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_len  = (value == 8'd0) ? 8'd1 : value;
      shadow_head = 8'd0;
      shadow_tail = 8'd0;
      shadow_fill = 9'd0;
      length_writes++;
   endtask

   function automatic logic [7:0] pick_offset();
      case ($urandom_range(0, 9))
         6:       return shadow_fill[7:0];
         7:       return shadow_len;
         8:       return shadow_len + 8'd1;
         9:       return 8'($urandom_range(0, 255));
         default: return (shadow_fill == 9'd0) ? 8'd0
                          : 8'($urandom_range(0, shadow_fill - 1));
      endcase
   endfunction

   function automatic brfp_pkg::req_type random_request(input int add_w, input int rem_w,
                                                        input int peek_w);
      int                roll;
      brfp_pkg::req_type r;
      roll          = $urandom_range(0, 99);
      r.write_byte  = 8'($urandom_range(0, 255));
      r.peek_offset = 8'($urandom_range(0, 255));
      if (roll < add_w) begin
         r.func = brfp_pkg::FN_ADD;
      end else if (roll < add_w + rem_w) begin
         r.func = brfp_pkg::FN_REMOVE;
      end else if (roll < add_w + rem_w + peek_w) begin
         r.func        = brfp_pkg::FN_PEEK;
         r.peek_offset = pick_offset();
      end else begin
         r.func = FN_UNUSED;
      end
      return r;
   endfunction

   task automatic run_phase(input int count, input int add_w, input int rem_w,
                            input int peek_w);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 39) == 0) begin
            wait_all_results();
         end
         issue(random_request(add_w, rem_w, peek_w));
      end
   endtask

   task automatic test_after_reset();
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'hff));
      send_request(req_of(FN_UNUSED,           8'hff, 8'hff));
      send_request(req_of(brfp_pkg::FN_ADD,    8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_ADD,    8'hff, 8'hff));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h01));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h02));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
   endtask

   task automatic test_length_one();
      write_length(8'd1);
      send_request(req_of(brfp_pkg::FN_ADD,    8'ha5, 8'h00));
      send_request(req_of(brfp_pkg::FN_ADD,    8'h5a, 8'h00));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h01));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h02));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
   endtask

   // tail and peek both wrap around a two-slot ring
   task automatic test_wrap_length_two();
      write_length(8'd2);
      send_request(req_of(brfp_pkg::FN_ADD,    8'h11, 8'h00));
      send_request(req_of(brfp_pkg::FN_ADD,    8'h22, 8'h00));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_ADD,    8'h33, 8'h00));
      send_request(req_of(brfp_pkg::FN_PEEK,   8'h00, 8'h01));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
      send_request(req_of(brfp_pkg::FN_REMOVE, 8'h00, 8'h00));
   endtask

   task automatic test_random_traffic();
      write_length(8'd255);
      run_phase(300, 92, 0, 6);
      run_phase(80, 10, 80, 8);
      write_length(8'd1);
      run_phase(40, 35, 35, 25);
      write_length(8'd2);
      run_phase(40, 35, 35, 25);
      write_length(8'($urandom_range(3, 16)));
      run_phase(50, 40, 30, 25);
      write_length(8'd0);
      run_phase(20, 35, 35, 25);
      write_length(8'($urandom_range(17, 254)));
      run_phase(40, 45, 25, 25);
   endtask

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= 8'd0;
      shadow_len  = 8'd255;
      shadow_head = 8'd0;
      shadow_tail = 8'd0;
      shadow_fill = 9'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_after_reset();
      test_length_one();
      test_wrap_length_two();
      test_random_traffic();

      wait_all_results();
      repeat (4) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $display("%0t: %0d transactions never returned", $time, rsp_due.size());
         mismatches++;
      end
      $display("requests: %0d add, %0d remove, %0d peek, %0d unknown; %0d length writes",
               req_by_func[brfp_pkg::FN_ADD], req_by_func[brfp_pkg::FN_REMOVE],
               req_by_func[brfp_pkg::FN_PEEK], req_by_func[FN_UNUSED], length_writes);
      $display("statuses: %0d ok, %0d full, %0d empty, %0d bad access",
               status_seen[brfp_pkg::ST_OK], status_seen[brfp_pkg::ST_FULL],
               status_seen[brfp_pkg::ST_EMPTY], status_seen[brfp_pkg::ST_BAD]);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
